// ===== rtl/q2e_pkg.sv =====
// Shared types, widths and constants of the quaternion to Euler angle block.
// Holds the CORDIC arctangent table, the CORDIC start helper and the rounding helper.
// No dependencies.
package q2e_pkg;

    localparam int PROD_W     = 32;
    localparam int SUM_W      = 34;
    localparam int SINE_W     = 32;
    localparam int CW         = 36;
    localparam int ACC_W      = 32;
    localparam int SQ_W       = 62;
    localparam int ANGLE_W    = 16;
    localparam int SQRT_STEPS = 31;
    localparam int SQRT_TOP_BIT = 60;
    localparam int ANGLE_DELAY  = SQRT_STEPS + 1;

    localparam logic signed [SUM_W-1:0] ONE_Q30     = 34'sh040000000;
    localparam logic signed [SUM_W-1:0] NEG_ONE_Q30 = -ONE_Q30;
    localparam logic [SQ_W-1:0]         SQRT_TOP    = SQ_W'(1) << SQRT_TOP_BIT;
    localparam logic [ACC_W-1:0]        ACC_PI      = 32'h80000000;
    localparam logic [ACC_W-1:0]        ACC_HALF    = 32'h00008000;
    localparam logic signed [ANGLE_W-1:0] HALF_PI   = 16'sd16384;
    localparam logic signed [ANGLE_W-1:0] NEG_HALF_PI = -16'sd16384;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ACC_W-1:0]     acc;
        logic                 zero;
        logic                 flag;
    } cordic_t;

    typedef struct packed {
        logic [SQ_W-1:0]          n;
        logic [SQ_W-1:0]          r;
        logic signed [SINE_W-1:0] sp;
        logic                     flag;
    } sqrt_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        logic                      clamped;
    } euler_t;

    function automatic logic [ACC_W-1:0] atan_entry(input int idx);
        logic [ACC_W-1:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // vector start: turn by pi when x is negative
    function automatic cordic_t cordic_start(input logic signed [SUM_W-1:0] y,
                                             input logic signed [SUM_W-1:0] x);
        cordic_t c;
        c.x    = (x < 0) ? -CW'(x) : CW'(x);
        c.y    = (x < 0) ? -CW'(y) : CW'(y);
        c.acc  = (x < 0) ? ACC_PI : '0;
        c.zero = (x == 0) && (y == 0);
        c.flag = 1'b0;
        return c;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] round_angle(input cordic_t c);
        logic [ACC_W-1:0] s;
        s = c.acc + ACC_HALF;
        return c.zero ? '0 : $signed(s[ACC_W-1:ACC_W-ANGLE_W]);
    endfunction

endpackage

// ===== rtl/q2e_if.sv =====
// Valid/ready channel interfaces for quaternion beats and Euler angle beats.
// Depends on nothing.
interface q2e_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    output ready);
endinterface

// ===== rtl/q2e_sqrt_cell.sv =====
// One step of the restoring integer square root chain.
// Depends on q2e_pkg.
module q2e_sqrt_cell #(
    parameter int BIT_POS = 60
) (
    input  logic           clk,
    input  logic           en,
    input  q2e_pkg::sqrt_t d,
    output q2e_pkg::sqrt_t q
);

    localparam logic [q2e_pkg::SQ_W-1:0] BITV = q2e_pkg::SQ_W'(1) << BIT_POS;

    q2e_pkg::sqrt_t          q_reg;
    q2e_pkg::sqrt_t          q_next;
    logic [q2e_pkg::SQ_W-1:0] trial;

    always_comb
    begin
        trial  = d.r + BITV;
        q_next = d;
        if (d.n >= trial)
        begin
            q_next.n = d.n - trial;
            q_next.r = (d.r >> 1) + BITV;
        end
        else
        begin
            q_next.r = d.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/q2e_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation with its arctangent constant.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             clk,
    input  logic             en,
    input  q2e_pkg::cordic_t d,
    output q2e_pkg::cordic_t q
);

    localparam logic [q2e_pkg::ACC_W-1:0] ATAN = q2e_pkg::atan_entry(STAGE);

    q2e_pkg::cordic_t          q_reg;
    q2e_pkg::cordic_t          q_next;
    logic signed [q2e_pkg::CW-1:0] xs;
    logic signed [q2e_pkg::CW-1:0] ys;

    always_comb
    begin
        xs     = d.x >>> STAGE;
        ys     = d.y >>> STAGE;
        q_next = d;
        if (d.y > 0)
        begin
            q_next.x   = d.x + ys;
            q_next.y   = d.y - xs;
            q_next.acc = d.acc + ATAN;
        end
        else
        begin
            q_next.x   = d.x - ys;
            q_next.y   = d.y + xs;
            q_next.acc = d.acc - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/q2e_out_skid.sv =====
// Output register with skid stage; produces the pipeline advance enable.
// Depends on q2e_pkg and q2e_euler_if.
module q2e_out_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pipe_valid,
    input  q2e_pkg::euler_t pipe_data,
    output logic            en,
    q2e_euler_if.source     euler
);

    logic            out_valid_reg;
    logic            skid_valid_reg;
    q2e_pkg::euler_t out_data_reg;
    q2e_pkg::euler_t skid_data_reg;
    logic            push;
    logic            out_free;

    assign en       = !skid_valid_reg;
    assign push     = pipe_valid && en;
    assign out_free = !out_valid_reg || euler.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end
        else if (push)
        begin
            skid_data_reg <= pipe_data;
        end
    end

    assign euler.valid         = out_valid_reg;
    assign euler.roll_angle    = out_data_reg.roll;
    assign euler.pitch_angle   = out_data_reg.pitch;
    assign euler.yaw_angle     = out_data_reg.yaw;
    assign euler.pitch_clamped = out_data_reg.clamped;

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// Quaternion to roll, pitch and yaw (Z-Y-X) top level.
// Depends on q2e_pkg, q2e_if, q2e_sqrt_cell, q2e_cordic_cell, q2e_out_skid.
//
// Takes one quaternion beat per clock and gives one angle beat per clock
// while the output is not stalled. An accepted beat passes through
// registers of products, sums and squaring, a 31-cell square root chain
// for the pitch cosine, then a chain of CORDIC_STAGES micro-rotation cells
// per angle; roll and yaw wait in a 32-deep delay line to line up with
// pitch. All stages advance together; a skid stage at the output keeps
// ready registered, so input stalls only once the output has been held
// for two beats.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    q2e_quat_if.sink    quat,
    q2e_euler_if.source euler
);

    localparam int PIPE_LEN = 4 + q2e_pkg::SQRT_STEPS + CORDIC_STAGES;
    localparam int PW = q2e_pkg::PROD_W;
    localparam int SW = q2e_pkg::SUM_W;

    logic                en;
    logic                accept;
    logic [PIPE_LEN-1:0] valid_reg;

    logic signed [PW-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [PW-1:0] p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;

    logic signed [SW-1:0] sr_reg, cr_reg, sy_reg, cy_reg;
    logic signed [SW-1:0] sr_next, cr_next, sy_next, cy_next, sp_raw;
    logic signed [q2e_pkg::SINE_W-1:0] sp_reg, sp_next, sp_s3_reg;
    logic                 flag_reg, flag_next, flag_s3_reg;

    q2e_pkg::cordic_t     roll_start_reg, yaw_start_reg;
    logic [q2e_pkg::SQ_W-1:0] sq_reg;
    logic signed [63:0]   sq_full;
    q2e_pkg::sqrt_t       s4_reg;

    q2e_pkg::sqrt_t       sq_chain [q2e_pkg::SQRT_STEPS+1];
    q2e_pkg::cordic_t     roll_chain [CORDIC_STAGES+1];
    q2e_pkg::cordic_t     yaw_chain [CORDIC_STAGES+1];
    q2e_pkg::cordic_t     pitch_chain [CORDIC_STAGES+1];

    logic signed [q2e_pkg::ANGLE_W-1:0] roll_dly_reg [q2e_pkg::ANGLE_DELAY];
    logic signed [q2e_pkg::ANGLE_W-1:0] yaw_dly_reg [q2e_pkg::ANGLE_DELAY];
    logic signed [q2e_pkg::ANGLE_W-1:0] pitch_round, pitch_sat;
    q2e_pkg::euler_t      result;

    assign quat.ready = en;
    assign accept     = quat.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_LEN-2:0], accept};
        end
    end

    always_comb
    begin
        sr_next = (SW'(p_wx_reg) + SW'(p_yz_reg)) <<< 1;
        cr_next = q2e_pkg::ONE_Q30 - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
        sy_next = (SW'(p_wz_reg) + SW'(p_xy_reg)) <<< 1;
        cy_next = q2e_pkg::ONE_Q30 - ((SW'(p_yy_reg) + SW'(p_zz_reg)) <<< 1);
        sp_raw  = (SW'(p_wy_reg) - SW'(p_zx_reg)) <<< 1;
        flag_next = 1'b0;
        sp_next   = q2e_pkg::SINE_W'(sp_raw);
        if (sp_raw > q2e_pkg::ONE_Q30)
        begin
            sp_next   = q2e_pkg::SINE_W'(q2e_pkg::ONE_Q30);
            flag_next = 1'b1;
        end
        else if (sp_raw < q2e_pkg::NEG_ONE_Q30)
        begin
            sp_next   = q2e_pkg::SINE_W'(q2e_pkg::NEG_ONE_Q30);
            flag_next = 1'b1;
        end
    end

    assign sq_full = sp_reg * sp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wx_reg <= quat.quat_w * quat.quat_x;
            p_yz_reg <= quat.quat_y * quat.quat_z;
            p_xx_reg <= quat.quat_x * quat.quat_x;
            p_yy_reg <= quat.quat_y * quat.quat_y;
            p_wz_reg <= quat.quat_w * quat.quat_z;
            p_xy_reg <= quat.quat_x * quat.quat_y;
            p_zz_reg <= quat.quat_z * quat.quat_z;
            p_wy_reg <= quat.quat_w * quat.quat_y;
            p_zx_reg <= quat.quat_z * quat.quat_x;

            sr_reg   <= sr_next;
            cr_reg   <= cr_next;
            sy_reg   <= sy_next;
            cy_reg   <= cy_next;
            sp_reg   <= sp_next;
            flag_reg <= flag_next;

            roll_start_reg <= q2e_pkg::cordic_start(sr_reg, cr_reg);
            yaw_start_reg  <= q2e_pkg::cordic_start(sy_reg, cy_reg);
            sq_reg         <= sq_full[q2e_pkg::SQ_W-1:0];
            sp_s3_reg      <= sp_reg;
            flag_s3_reg    <= flag_reg;

            s4_reg.n    <= q2e_pkg::SQRT_TOP - sq_reg;
            s4_reg.r    <= '0;
            s4_reg.sp   <= sp_s3_reg;
            s4_reg.flag <= flag_s3_reg;
        end
    end

    assign sq_chain[0] = s4_reg;

    genvar gi;
    generate
        for (gi = 0; gi < q2e_pkg::SQRT_STEPS; gi++)
        begin : g_sqrt
            q2e_sqrt_cell #(
                .BIT_POS(q2e_pkg::SQRT_TOP_BIT - 2 * gi)
            ) u_cell (
                .clk(clk),
                .en (en),
                .d  (sq_chain[gi]),
                .q  (sq_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        pitch_chain[0] = q2e_pkg::cordic_start(
            SW'(sq_chain[q2e_pkg::SQRT_STEPS].sp),
            SW'($signed({1'b0, sq_chain[q2e_pkg::SQRT_STEPS].r[30:0]})));
        pitch_chain[0].flag = sq_chain[q2e_pkg::SQRT_STEPS].flag;
    end

    assign roll_chain[0] = roll_start_reg;
    assign yaw_chain[0]  = yaw_start_reg;

    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++)
        begin : g_cordic
            q2e_cordic_cell #(.STAGE(gi)) u_roll (
                .clk(clk), .en(en), .d(roll_chain[gi]), .q(roll_chain[gi+1])
            );
            q2e_cordic_cell #(.STAGE(gi)) u_yaw (
                .clk(clk), .en(en), .d(yaw_chain[gi]), .q(yaw_chain[gi+1])
            );
            q2e_cordic_cell #(.STAGE(gi)) u_pitch (
                .clk(clk), .en(en), .d(pitch_chain[gi]), .q(pitch_chain[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_dly_reg[0] <= q2e_pkg::round_angle(roll_chain[CORDIC_STAGES]);
            yaw_dly_reg[0]  <= q2e_pkg::round_angle(yaw_chain[CORDIC_STAGES]);
            for (int i = 1; i < q2e_pkg::ANGLE_DELAY; i++)
            begin
                roll_dly_reg[i] <= roll_dly_reg[i-1];
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
            end
        end
    end

    always_comb
    begin
        pitch_round = q2e_pkg::round_angle(pitch_chain[CORDIC_STAGES]);
        pitch_sat   = pitch_round;
        if (pitch_round > q2e_pkg::HALF_PI)
        begin
            pitch_sat = q2e_pkg::HALF_PI;
        end
        else if (pitch_round < q2e_pkg::NEG_HALF_PI)
        begin
            pitch_sat = q2e_pkg::NEG_HALF_PI;
        end
        result.roll    = roll_dly_reg[q2e_pkg::ANGLE_DELAY-1];
        result.pitch   = pitch_sat;
        result.yaw     = yaw_dly_reg[q2e_pkg::ANGLE_DELAY-1];
        result.clamped = pitch_chain[CORDIC_STAGES].flag;
    end

    q2e_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .pipe_valid(valid_reg[PIPE_LEN-1]),
        .pipe_data (result),
        .en        (en),
        .euler     (euler)
    );

endmodule
